/* sv/cond_instr_decode_and_branch_macros.svh */
// Assertion macros for the condition check and instruction decode block.
// Used by the checker; expects clk_i and rst_ni in scope.
`ifndef COND_INSTR_DECODE_AND_BRANCH_MACROS_SVH
`define COND_INSTR_DECODE_AND_BRANCH_MACROS_SVH

// same-cycle implication
`define CIDB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cidb check failed");

// next-cycle implication
`define CIDB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cidb check failed");

`endif

/* sv/cidb_pkg.sv */
// Types, codes and decode patterns for the condition check and decode block.
// No dependencies.
package cidb_pkg;

  localparam int unsigned InTdataW  = 72;
  localparam int unsigned OutTdataW = 80;

  typedef enum logic [3:0] {
    CLS_MUL      = 4'd0,
    CLS_SWAP     = 4'd1,
    CLS_MRS      = 4'd2,
    CLS_MSR_REG  = 4'd3,
    CLS_MSR_IMM  = 4'd4,
    CLS_UNDEF    = 4'd5,
    CLS_DP       = 4'd6,
    CLS_LDST_IMM = 4'd7,
    CLS_LDST_REG = 4'd8,
    CLS_LDST_M   = 4'd9,
    CLS_BRANCH   = 4'd10,
    CLS_SWI      = 4'd11
  } cidb_class_e;

  typedef enum logic [3:0] {
    CC_EQ = 4'd0,  CC_NE = 4'd1,  CC_CS = 4'd2,  CC_CC = 4'd3,
    CC_MI = 4'd4,  CC_PL = 4'd5,  CC_VS = 4'd6,  CC_VC = 4'd7,
    CC_HI = 4'd8,  CC_LS = 4'd9,  CC_GE = 4'd10, CC_LT = 4'd11,
    CC_GT = 4'd12, CC_LE = 4'd13, CC_AL = 4'd14, CC_NV = 4'd15
  } cidb_cond_e;

  localparam logic [11:0] KeyMaskMul  = 12'hfcf;
  localparam logic [11:0] KeyPatMul   = 12'h009;
  localparam logic [11:0] KeyMaskPsr  = 12'hfbf;
  localparam logic [11:0] KeyPatSwap  = 12'h109;
  localparam logic [11:0] KeyPatMrs   = 12'h100;
  localparam logic [11:0] KeyPatMsrR  = 12'h120;
  localparam logic [11:0] KeyMaskImm  = 12'hfb0;
  localparam logic [11:0] KeyPatMsrI  = 12'h320;
  localparam logic [11:0] KeyPatUndef = 12'h300;
  localparam logic [11:0] KeyMaskGrp  = 12'he00;
  localparam logic [11:0] KeyPatDpR   = 12'h000;
  localparam logic [11:0] KeyPatDpI   = 12'h200;
  localparam logic [11:0] KeyPatLdI   = 12'h400;
  localparam logic [11:0] KeyPatLdR   = 12'h600;
  localparam logic [11:0] KeyPatLdM   = 12'h800;
  localparam logic [11:0] KeyPatBr    = 12'ha00;
  localparam logic [11:0] KeyMaskSwi  = 12'hf00;
  localparam logic [11:0] KeyPatSwi   = 12'hf00;

  localparam logic [31:0] SwiVector = 32'h0000_0008;
  localparam logic [31:0] PcToLink  = 32'h0000_0004;

  typedef struct packed {
    logic [31:0] opcode;
    logic [31:0] pc_value;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
  } cidb_item_t;

  typedef struct packed {
    cidb_class_e instr_class;
    logic [3:0]  alu_op;
  } cidb_decode_t;

  typedef struct packed {
    logic        redirect;
    logic [31:0] target;
    logic        link_write;
    logic [31:0] link_value;
    logic        enter_supervisor;
  } cidb_flow_t;

  typedef struct packed {
    logic         cond_pass;
    cidb_decode_t dec;
    cidb_flow_t   flow;
  } cidb_result_t;

endpackage

/* sv/cond_instr_decode_and_branch.sv */
// Top level: input register, condition check, class decode, branch unit and
// result register. Depends on cidb_pkg, cidb_cond, cidb_class, cidb_branch.
//
// One instruction per transfer on the s_axis channel: instruction word,
// program counter as read (address plus eight) and the N, Z, C, V flags.
// One result per instruction on the m_axis channel: condition pass, class,
// ALU opcode, redirect and target, link write and link value, and the
// supervisor entry flag. Results leave in the order instructions arrive.
// An instruction is first held in the input register, then passes through the
// decode logic into the result register, which shows the result. Throughput
// is one instruction per cycle while the receiver does not stall, set by the two-register
// pipeline, each stage taking a new item whenever it is empty or drains.
// When the receiver stalls the result register holds, then the input
// register fills and s_axis_tready falls. Reset empties both registers.
module cond_instr_decode_and_branch (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // opcode[31:0], pc_value[63:32], flag_n[64], flag_z[65], flag_c[66], flag_v[67], pad
  input  logic [cidb_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // cond_pass[0], instr_class[4:1], alu_op[8:5], redirect[9], target[41:10],
  // link_write[42], link_value[74:43], enter_supervisor[75], pad
  output logic [cidb_pkg::OutTdataW-1:0] m_axis_tdata
);
  import cidb_pkg::*;

  logic         in_valid_q;
  cidb_item_t   item_q;
  cidb_item_t   item_d;
  logic         out_valid_q;
  cidb_result_t res_q;
  cidb_result_t res_d;
  logic         out_ready;
  logic         advance;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign advance       = in_valid_q && out_ready;

  assign item_d.opcode   = s_axis_tdata[31:0];
  assign item_d.pc_value = s_axis_tdata[63:32];
  assign item_d.flag_n   = s_axis_tdata[64];
  assign item_d.flag_z   = s_axis_tdata[65];
  assign item_d.flag_c   = s_axis_tdata[66];
  assign item_d.flag_v   = s_axis_tdata[67];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  cidb_cond u_cond (
    .cond_i   (item_q.opcode[31:28]),
    .flag_n_i (item_q.flag_n),
    .flag_z_i (item_q.flag_z),
    .flag_c_i (item_q.flag_c),
    .flag_v_i (item_q.flag_v),
    .pass_o   (res_d.cond_pass)
  );

  cidb_class u_class (
    .opcode_i (item_q.opcode),
    .dec_o    (res_d.dec)
  );

  cidb_branch u_branch (
    .opcode_i      (item_q.opcode),
    .pc_value_i    (item_q.pc_value),
    .pass_i        (res_d.cond_pass),
    .instr_class_i (res_d.dec.instr_class),
    .flow_o        (res_d.flow)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000,
                          res_q.flow.enter_supervisor,
                          res_q.flow.link_value,
                          res_q.flow.link_write,
                          res_q.flow.target,
                          res_q.flow.redirect,
                          res_q.dec.alu_op,
                          res_q.dec.instr_class,
                          res_q.cond_pass};

endmodule

/* sv/cidb_cond.sv */
// Condition field evaluation against the N, Z, C and V flags.
// Depends on cidb_pkg.
module cidb_cond (
  input  logic [3:0] cond_i,
  input  logic       flag_n_i,
  input  logic       flag_z_i,
  input  logic       flag_c_i,
  input  logic       flag_v_i,
  output logic       pass_o
);
  import cidb_pkg::*;

  always_comb begin
    case (cidb_cond_e'(cond_i))
      CC_EQ:   pass_o = flag_z_i;
      CC_NE:   pass_o = !flag_z_i;
      CC_CS:   pass_o = flag_c_i;
      CC_CC:   pass_o = !flag_c_i;
      CC_MI:   pass_o = flag_n_i;
      CC_PL:   pass_o = !flag_n_i;
      CC_VS:   pass_o = flag_v_i;
      CC_VC:   pass_o = !flag_v_i;
      CC_HI:   pass_o = flag_c_i && !flag_z_i;
      CC_LS:   pass_o = !flag_c_i || flag_z_i;
      CC_GE:   pass_o = (flag_n_i == flag_v_i);
      CC_LT:   pass_o = (flag_n_i != flag_v_i);
      CC_GT:   pass_o = !flag_z_i && (flag_n_i == flag_v_i);
      CC_LE:   pass_o = flag_z_i || (flag_n_i != flag_v_i);
      CC_AL:   pass_o = 1'b1;
      default: pass_o = 1'b0;
    endcase
  end

endmodule

/* sv/cidb_class.sv */
// Instruction class decode from bits 27:20 and 7:4, in priority order.
// Depends on cidb_pkg.
module cidb_class (
  input  logic [31:0]           opcode_i,
  output cidb_pkg::cidb_decode_t dec_o
);
  import cidb_pkg::*;

  logic [11:0] key;

  assign key = {opcode_i[27:20], opcode_i[7:4]};

  always_comb begin
    if ((key & KeyMaskMul) == KeyPatMul) begin
      dec_o.instr_class = CLS_MUL;
    end else if ((key & KeyMaskPsr) == KeyPatSwap) begin
      dec_o.instr_class = CLS_SWAP;
    end else if ((key & KeyMaskPsr) == KeyPatMrs) begin
      dec_o.instr_class = CLS_MRS;
    end else if ((key & KeyMaskPsr) == KeyPatMsrR) begin
      dec_o.instr_class = CLS_MSR_REG;
    end else if ((key & KeyMaskImm) == KeyPatMsrI) begin
      dec_o.instr_class = CLS_MSR_IMM;
    end else if ((key & KeyMaskImm) == KeyPatUndef) begin
      dec_o.instr_class = CLS_UNDEF;
    end else if ((key & KeyMaskGrp) == KeyPatDpR || (key & KeyMaskGrp) == KeyPatDpI) begin
      dec_o.instr_class = CLS_DP;
    end else if ((key & KeyMaskGrp) == KeyPatLdI) begin
      dec_o.instr_class = CLS_LDST_IMM;
    end else if ((key & KeyMaskGrp) == KeyPatLdR) begin
      dec_o.instr_class = CLS_LDST_REG;
    end else if ((key & KeyMaskGrp) == KeyPatLdM) begin
      dec_o.instr_class = CLS_LDST_M;
    end else if ((key & KeyMaskGrp) == KeyPatBr) begin
      dec_o.instr_class = CLS_BRANCH;
    end else if ((key & KeyMaskSwi) == KeyPatSwi) begin
      dec_o.instr_class = CLS_SWI;
    end else begin
      dec_o.instr_class = CLS_UNDEF;
    end
    dec_o.alu_op = (dec_o.instr_class == CLS_DP) ? opcode_i[24:21] : 4'd0;
  end

endmodule

/* sv/cidb_branch.sv */
// Branch target, link value and software interrupt entry for passing items.
// Depends on cidb_pkg.
module cidb_branch (
  input  logic [31:0]           opcode_i,
  input  logic [31:0]           pc_value_i,
  input  logic                  pass_i,
  input  cidb_pkg::cidb_class_e instr_class_i,
  output cidb_pkg::cidb_flow_t  flow_o
);
  import cidb_pkg::*;

  logic [31:0] offset;
  logic [31:0] br_target;

  assign offset    = {{6{opcode_i[23]}}, opcode_i[23:0], 2'b00};
  assign br_target = pc_value_i + offset;

  always_comb begin
    flow_o.redirect         = 1'b0;
    flow_o.target           = '0;
    flow_o.link_write       = 1'b0;
    flow_o.link_value       = pc_value_i - PcToLink;
    flow_o.enter_supervisor = 1'b0;
    if (pass_i && instr_class_i == CLS_BRANCH) begin
      flow_o.redirect   = 1'b1;
      flow_o.target     = {br_target[31:2], 2'b00};
      flow_o.link_write = opcode_i[24];
    end else if (pass_i && instr_class_i == CLS_SWI) begin
      flow_o.redirect         = 1'b1;
      flow_o.target           = SwiVector;
      flow_o.link_write       = 1'b1;
      flow_o.enter_supervisor = 1'b1;
    end
  end

endmodule

/* sv/cidb_checker.sv */
// Port-level checks for the decode block, bound to the top level.
// Depends on cidb_pkg and cond_instr_decode_and_branch_macros.svh.
`include "cond_instr_decode_and_branch_macros.svh"

module cidb_port_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [cidb_pkg::OutTdataW-1:0] m_axis_tdata
);
  import cidb_pkg::*;

  logic out_redirect;
  logic out_alu_set;
  logic out_svc;
  logic out_swi_ok;
  logic out_stall;

  assign out_redirect = m_axis_tvalid && m_axis_tdata[9];
  assign out_alu_set  = m_axis_tvalid && m_axis_tdata[8:5] != 4'd0;
  assign out_svc      = m_axis_tvalid && m_axis_tdata[75];
  assign out_swi_ok   = m_axis_tdata[9] && m_axis_tdata[42] &&
                        m_axis_tdata[41:10] == SwiVector && m_axis_tdata[4:1] == CLS_SWI;
  assign out_stall    = m_axis_tvalid && !m_axis_tready;

  `CIDB_ASSERT_IMPL(a_redirect_needs_pass, out_redirect, m_axis_tdata[0])
  `CIDB_ASSERT_IMPL(a_swi_entry, out_svc, out_swi_ok)
  `CIDB_ASSERT_IMPL(a_alu_dp_only, out_alu_set, m_axis_tdata[4:1] == CLS_DP)
  `CIDB_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind cond_instr_decode_and_branch cidb_port_checker u_cidb_checker (.*);
